// ===== hw/rtl/dsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsdc_pkg
// Shared constants and the month table for the date span day counter.
// ----------------------------------------------------------------------------
package dsdc_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int SPAN_W  = 23;

  localparam int SPAN_MAX = 4194303;
  localparam int SPAN_MIN = -4194304;

  localparam int DAYS_YEAR   = 365;
  localparam int MONTHS_YEAR = 12;
  localparam int MARCH_IDX   = 2;

  localparam int DIV_CENTURY = 100;
  localparam int DIV_QUAD    = 400;
  localparam int DIV_MILL    = 4000;

  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [SPAN_W-1:0]  span_t;

  // Days in a common year before the first of the month (month index 0..11).
  function automatic logic [8:0] days_before(input month_t mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/date_span_day_counter.sv =====
// ----------------------------------------------------------------------------
// date_span_day_counter
// Signed number of days from a start date to an end date (Gregorian, with
// years divisible by 4000 not leap).
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------
//   in      | start / busy       | in_start_{month,day,year}, in_end_*
//   out     | out_valid (strobe) | out_day_span
//
// One date pair is taken every cycle; busy is always low.
// The strobe and the result pass through the constant-divider pipeline
// (reciprocal multiply, back-multiply), the day-number sums and the final
// span register.
// Reset clears the valid pipeline only; no result is lost or stalled.
// ----------------------------------------------------------------------------
module date_span_day_counter #(
  parameter int YEAR_MAX = 9999
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  dsdc_pkg::month_t in_start_month,
  input  dsdc_pkg::day_t   in_start_day,
  input  dsdc_pkg::year_t  in_start_year,
  input  dsdc_pkg::month_t in_end_month,
  input  dsdc_pkg::day_t   in_end_day,
  input  dsdc_pkg::year_t  in_end_year,
  output logic             out_valid,
  output dsdc_pkg::span_t  out_day_span
);
  import dsdc_pkg::*;

  localparam int NW    = $clog2(366 * YEAR_MAX + 400);
  localparam int DW    = NW + 1;
  localparam int CW    = (DW > SPAN_W + 1) ? DW : SPAN_W + 1;
  localparam int LAT   = 6;
  localparam logic signed [CW-1:0] SMAX = CW'(SPAN_MAX);
  localparam logic signed [CW-1:0] SMIN = CW'(SPAN_MIN);

  logic [NW-1:0]        n_start;
  logic [NW-1:0]        n_end;
  logic signed [CW-1:0] diff;
  span_t                span_nxt;
  span_t                span_r;
  logic [LAT-1:0]       vld_r;
  logic [LAT-1:0]       vld_nxt;

  assign busy = 1'b0;

  dsdc_day_num #(.YEAR_MAX(YEAR_MAX), .NW(NW)) u_start (
    .clk     (clk),
    .month   (in_start_month),
    .day     (in_start_day),
    .year    (in_start_year),
    .day_num (n_start)
  );

  dsdc_day_num #(.YEAR_MAX(YEAR_MAX), .NW(NW)) u_end (
    .clk     (clk),
    .month   (in_end_month),
    .day     (in_end_day),
    .year    (in_end_year),
    .day_num (n_end)
  );

  always_comb begin
    diff = $signed(CW'(n_end) - CW'(n_start));
    if (diff > SMAX) begin
      span_nxt = SMAX[SPAN_W-1:0];
    end else if (diff < SMIN) begin
      span_nxt = SMIN[SPAN_W-1:0];
    end else begin
      span_nxt = diff[SPAN_W-1:0];
    end
    vld_nxt = {vld_r[LAT-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_day_span = span_r;

endmodule

// ===== hw/rtl/dsdc_cdiv.sv =====
// ----------------------------------------------------------------------------
// dsdc_cdiv
// Divide by a constant: reciprocal multiply, back-multiply, one-step correction.
// ----------------------------------------------------------------------------
module dsdc_cdiv #(
  parameter int D  = 100,
  parameter int XW = 14
) (
  input  logic          clk,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] q,
  output logic [XW-1:0] r
);

  localparam int K  = XW + 1;
  localparam int MW = K;
  localparam logic [MW-1:0] RECIP = MW'((1 << K) / D);

  logic [XW+MW-1:0] prod;
  logic [XW-1:0]    x_r;
  logic [XW-1:0]    q0_r;
  logic [31:0]      dq;
  logic [XW-1:0]    rem0_nxt;
  logic [XW-1:0]    rem0_r;
  logic [XW-1:0]    q0_rr;
  logic             ge;

  assign prod = (XW+MW)'(x) * (XW+MW)'(RECIP);

  always_ff @(posedge clk) begin
    x_r  <= x;
    q0_r <= prod[XW+MW-1:K];
  end

  assign dq       = 32'(D) * 32'(q0_r);
  assign rem0_nxt = x_r - dq[XW-1:0];

  always_ff @(posedge clk) begin
    rem0_r <= rem0_nxt;
    q0_rr  <= q0_r;
  end

  assign ge = 32'(rem0_r) >= 32'(D);
  assign q  = q0_rr + XW'(ge);
  assign r  = ge ? (rem0_r - XW'(D)) : rem0_r;

endmodule

// ===== hw/rtl/dsdc_day_num.sv =====
// ----------------------------------------------------------------------------
// dsdc_day_num
// Day number of one date from the epoch, five register stages.
// ----------------------------------------------------------------------------
module dsdc_day_num #(
  parameter int YEAR_MAX = 9999,
  parameter int NW       = 22
) (
  input  logic            clk,
  input  dsdc_pkg::month_t month,
  input  dsdc_pkg::day_t   day,
  input  dsdc_pkg::year_t  year,
  output logic [NW-1:0]   day_num
);
  import dsdc_pkg::*;

  localparam int YW = $clog2(YEAR_MAX + 1);

  logic [31:0]   year_ext;
  logic [YW-1:0] yc;
  month_t        mi_nxt;

  logic [YW-1:0] p_r;
  month_t        mi_r;
  day_t          day_r;

  logic [YW-1:0] p2_r;
  month_t        mi2_r;
  day_t          day2_r;
  logic [NW-1:0] p365_r;

  logic [YW-1:0] p3_r;
  month_t        mi3_r;
  day_t          day3_r;
  logic [NW-1:0] p365b_r;

  logic [YW-1:0] q100;
  logic [YW-1:0] r100;
  logic [YW-1:0] q400;
  logic [YW-1:0] r400;
  logic [YW-1:0] q4000;
  logic [YW-1:0] r4000;

  logic          leap;
  logic [NW-1:0] base_nxt;
  logic [9:0]    mday_nxt;
  logic [NW-1:0] base_r;
  logic [9:0]    mday_r;
  logic [NW-1:0] n_r;

  assign year_ext = 32'(year);

  always_comb begin
    if (year_ext == 32'd0) begin
      yc = YW'(1);
    end else if (year_ext > 32'(YEAR_MAX)) begin
      yc = YW'(YEAR_MAX);
    end else begin
      yc = YW'(year_ext);
    end
    if (month == month_t'(0)) begin
      mi_nxt = month_t'(0);
    end else if (month > month_t'(MONTHS_YEAR)) begin
      mi_nxt = month_t'(MONTHS_YEAR - 1);
    end else begin
      mi_nxt = month - month_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= yc - YW'(1);
    mi_r  <= mi_nxt;
    day_r <= day;
  end

  always_ff @(posedge clk) begin
    p2_r   <= p_r;
    mi2_r  <= mi_r;
    day2_r <= day_r;
    p365_r <= NW'(p_r) * NW'(DAYS_YEAR);
  end

  always_ff @(posedge clk) begin
    p3_r    <= p2_r;
    mi3_r   <= mi2_r;
    day3_r  <= day2_r;
    p365b_r <= p365_r;
  end

  dsdc_cdiv #(.D(DIV_CENTURY), .XW(YW)) u_div100 (
    .clk (clk),
    .x   (p_r),
    .q   (q100),
    .r   (r100)
  );

  dsdc_cdiv #(.D(DIV_QUAD), .XW(YW)) u_div400 (
    .clk (clk),
    .x   (p_r),
    .q   (q400),
    .r   (r400)
  );

  dsdc_cdiv #(.D(DIV_MILL), .XW(YW)) u_div4000 (
    .clk (clk),
    .x   (p_r),
    .q   (q4000),
    .r   (r4000)
  );

  // year = p + 1, so a divisibility test on the year is a top remainder on p
  always_comb begin
    leap = ((p3_r[1:0] == 2'b11) && (32'(r100) != 32'(DIV_CENTURY - 1))) ||
           ((32'(r400) == 32'(DIV_QUAD - 1)) && (32'(r4000) != 32'(DIV_MILL - 1)));
    base_nxt = p365b_r + NW'(p3_r >> 2) - NW'(q100) + NW'(q400) - NW'(q4000);
    mday_nxt = 10'(days_before(mi3_r)) + 10'(day3_r) +
               10'(leap && (mi3_r >= month_t'(MARCH_IDX)));
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    mday_r <= mday_nxt;
    n_r    <= base_r + NW'(mday_r);
  end

  assign day_num = n_r;

endmodule

// ===== dv/date_span_day_counter_tb.sv =====
// ----------------------------------------------------------------------------
// date_span_day_counter_tb
// Drives date pairs into the day counter through the start/busy handshake and
// checks every strobed span against a day-number predictor kept in a small
// scoreboard. A directed set covers calendar corners and out-of-range fields.
// A random set mixes valid dates, nearby pairs and raw field noise, with
// bursts of idle cycles on the input side.
// ----------------------------------------------------------------------------
module date_span_day_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsdc_pkg::*;

  localparam int YEAR_LIMIT   = 9999;
  localparam int RANDOM_PAIRS = 1950;

  typedef struct packed {
    month_t m;
    day_t   d;
    year_t  y;
  } date_t;

  class day_span_scoreboard;
    span_t expected_spans[$];
    int    mismatches;
    int    month_offset[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    static function bit leap_year(longint yr);
      return ((yr % 4 == 0) && (yr % DIV_CENTURY != 0)) ||
             ((yr % DIV_QUAD == 0) && (yr % DIV_MILL != 0));
    endfunction

    static function int month_days(int mi, longint yr);
      case (mi)
        2:             return leap_year(yr) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    function longint epoch_days(date_t dt);
      longint yr, p, n;
      int     mi;
      yr = longint'(dt.y);
      if (yr < 1) yr = 1;
      if (yr > YEAR_LIMIT) yr = YEAR_LIMIT;
      mi = int'(dt.m);
      if (mi < 1) mi = 1;
      if (mi > MONTHS_YEAR) mi = MONTHS_YEAR;
      p = yr - 1;
      n = DAYS_YEAR * p + p / 4 - p / DIV_CENTURY + p / DIV_QUAD - p / DIV_MILL;
      n += month_offset[mi-1];
      if (mi > MARCH_IDX && leap_year(yr)) n += 1;
      n += longint'(dt.d);
      return n;
    endfunction

    function void note_transfer(date_t a, date_t b);
      longint diff;
      diff = epoch_days(b) - epoch_days(a);
      if (diff > SPAN_MAX) diff = SPAN_MAX;
      if (diff < SPAN_MIN) diff = SPAN_MIN;
      expected_spans.push_back(span_t'(diff));
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (expected_spans.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: span %0d strobed with no transfer pending", $realtime,
                   $signed(got));
        mismatches++;
        return;
      end
      want = expected_spans.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("%0t: day_span mismatch: expected %0d, got %0d", $realtime,
                   $signed(want), $signed(got));
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction

    function int errors();
      return mismatches + expected_spans.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   start;
  logic   busy;
  month_t in_start_month;
  day_t   in_start_day;
  year_t  in_start_year;
  month_t in_end_month;
  day_t   in_end_day;
  year_t  in_end_year;
  logic   out_valid;
  span_t  out_day_span;

  day_span_scoreboard sb = new();

  always #5 clk = ~clk;

  date_span_day_counter #(
    .YEAR_MAX(YEAR_LIMIT)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_start_month(in_start_month),
    .in_start_day  (in_start_day),
    .in_start_year (in_start_year),
    .in_end_month  (in_end_month),
    .in_end_day    (in_end_day),
    .in_end_year   (in_end_year),
    .out_valid     (out_valid),
    .out_day_span  (out_day_span)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_transfer('{in_start_month, in_start_day, in_start_year},
                         '{in_end_month, in_end_day, in_end_year});
      if (out_valid) sb.check_span(out_day_span);
    end
  end

  task automatic send_pair(date_t a, date_t b);
    in_start_month <= a.m;
    in_start_day   <= a.d;
    in_start_year  <= a.y;
    in_end_month   <= b.m;
    in_end_day     <= b.d;
    in_end_year    <= b.y;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_spans(int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic year_t pick_year();
    int v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom_range(1, YEAR_LIMIT);
      2:    v = $urandom_range(1, 99) * DIV_CENTURY + $urandom_range(0, 2) - 1;
      3:    v = $urandom_range(1, 2) * DIV_MILL + $urandom_range(0, 2) - 1;
      4:    v = $urandom_range(1, 4);
      5:    v = $urandom_range(YEAR_LIMIT - 3, YEAR_LIMIT);
      default: v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(YEAR_LIMIT + 1, 16383);
    endcase
    return year_t'(v);
  endfunction

  function automatic date_t valid_date(year_t yr);
    date_t dt;
    longint ey;
    ey = (yr < 1) ? 1 : ((yr > YEAR_LIMIT) ? YEAR_LIMIT : longint'(yr));
    dt.y = yr;
    dt.m = month_t'($urandom_range(1, 12));
    dt.d = day_t'($urandom_range(1, day_span_scoreboard::month_days(int'(dt.m), ey)));
    return dt;
  endfunction

  function automatic date_t noise_date();
    date_t dt;
    dt.m = month_t'($urandom_range(0, 15));
    dt.d = day_t'($urandom_range(0, 31));
    dt.y = year_t'($urandom_range(0, 16383));
    return dt;
  endfunction

  function automatic date_t random_date();
    if ($urandom_range(0, 99) < 15) return noise_date();
    return valid_date(pick_year());
  endfunction

  function automatic date_t nearby_date(date_t a);
    int yr;
    yr = int'(a.y) + $urandom_range(0, 2) - 1;
    if (yr < 1 || yr > YEAR_LIMIT) return valid_date(pick_year());
    return valid_date(year_t'(yr));
  endfunction

  initial begin
    date_t a;
    date_t b;
    start          <= 1'b0;
    rst_n          <= 1'b0;
    in_start_month <= '0;
    in_start_day   <= '0;
    in_start_year  <= '0;
    in_end_month   <= '0;
    in_end_day     <= '0;
    in_end_year    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair('{4'd1, 5'd1, 14'd2000}, '{4'd1, 5'd1, 14'd2000});
    send_pair('{4'd1, 5'd1, 14'd1}, '{4'd12, 5'd31, 14'd9999});
    send_pair('{4'd12, 5'd31, 14'd9999}, '{4'd1, 5'd1, 14'd1});
    send_pair('{4'd2, 5'd28, 14'd2000}, '{4'd3, 5'd1, 14'd2000});
    send_pair('{4'd2, 5'd28, 14'd1900}, '{4'd3, 5'd1, 14'd1900});
    send_pair('{4'd2, 5'd28, 14'd4000}, '{4'd3, 5'd1, 14'd4000});
    send_pair('{4'd2, 5'd28, 14'd8000}, '{4'd3, 5'd1, 14'd8000});
    send_pair('{4'd2, 5'd28, 14'd2024}, '{4'd3, 5'd1, 14'd2024});
    send_pair('{4'd0, 5'd15, 14'd2020}, '{4'd1, 5'd15, 14'd2020});
    send_pair('{4'd15, 5'd1, 14'd2020}, '{4'd12, 5'd1, 14'd2020});
    send_pair('{4'd13, 5'd1, 14'd2020}, '{4'd12, 5'd1, 14'd2020});
    send_pair('{4'd3, 5'd0, 14'd2021}, '{4'd2, 5'd28, 14'd2021});
    send_pair('{4'd2, 5'd31, 14'd2021}, '{4'd3, 5'd3, 14'd2021});
    send_pair('{4'd6, 5'd15, 14'd0}, '{4'd6, 5'd15, 14'd1});
    send_pair('{4'd6, 5'd15, 14'd16383}, '{4'd6, 5'd15, 14'd9999});
    send_pair('{4'd1, 5'd1, 14'd10000}, '{4'd1, 5'd1, 14'd1});
    send_pair('{4'd15, 5'd31, 14'd16383}, '{4'd0, 5'd0, 14'd0});
    send_pair('{4'd0, 5'd0, 14'd0}, '{4'd15, 5'd31, 14'd16383});
    send_pair('{4'd12, 5'd31, 14'd1999}, '{4'd1, 5'd1, 14'd2000});
    send_pair('{4'd3, 5'd1, 14'd2100}, '{4'd2, 5'd28, 14'd2100});
    send_pair('{4'd1, 5'd1, 14'd3999}, '{4'd1, 5'd1, 14'd4001});
    send_pair('{4'd12, 5'd31, 14'd8000}, '{4'd1, 5'd1, 14'd8000});

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      a = random_date();
      if ($urandom_range(0, 99) < 35)
        b = nearby_date(a);
      else
        b = random_date();
      if ($urandom_range(0, 1) == 0) send_pair(a, b);
      else send_pair(b, a);
      if (i == RANDOM_PAIRS / 2) drain_spans(200);
      else if (i < RANDOM_PAIRS * 4 / 5 && (i % 300) >= 60 && $urandom_range(0, 4) == 0)
        idle_cycles($urandom_range(1, 15));
    end

    drain_spans(200);
    repeat (12) @(posedge clk);
    if (sb.errors() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dsdc_pkg.sv
hw/rtl/dsdc_cdiv.sv
hw/rtl/dsdc_day_num.sv
hw/rtl/date_span_day_counter.sv
dv/date_span_day_counter_tb.sv
